FILE: design/serial_packet_deframer_assert.svh
// ---------------------------------------------------------------------------
// Serial packet deframer assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef SERIAL_PACKET_DEFRAMER_ASSERT_SVH
`define SERIAL_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, disabled during reset
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication that also holds across reset
`define SPD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

FILE: design/spd_pkg.sv
// ---------------------------------------------------------------------------
// Serial packet deframer package
// Types, codes and helpers shared by the deframer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

   // Frame limits and fixed bytes
   localparam logic [7:0] MAX_PAYLOAD = 8'd128;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_ZERO   = 8'h00;

   // Register reset values
   localparam logic [7:0] HEAD_RESET  = 8'd204;
   localparam logic [7:0] TAIL_RESET  = 8'd185;

   // Register map: index taken from the word address
   localparam int unsigned ADDR_W     = 3;
   localparam logic        REG_HEAD   = 1'b0;
   localparam logic        REG_TAIL   = 1'b1;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_STRAY    = 3'd1,
      ERR_LENGTH   = 3'd2,
      ERR_TAIL     = 3'd3,
      ERR_CHECKSUM = 3'd4,
      ERR_CR       = 3'd5,
      ERR_LF       = 3'd6
   } spd_err_type;

   typedef enum logic [6:0] {
      PH_IDLE     = 7'b0000001,
      PH_LEN      = 7'b0000010,
      PH_PAYLOAD  = 7'b0000100,
      PH_TAIL     = 7'b0001000,
      PH_CHECKSUM = 7'b0010000,
      PH_CR       = 7'b0100000,
      PH_LF       = 7'b1000000
   } spd_phase_type;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] tail_byte;
   } spd_cfg_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        first_of_frame;
      logic        frame_done;
      logic        frame_good;
      spd_err_type error_code;
      logic [7:0]  frame_id;
      logic [7:0]  frame_length;
   } spd_result_type;

   // BSD checksum step: rotate right by one, then add the byte
   function automatic logic [7:0] bsd_add(input logic [7:0] sum, input logic [7:0] b);
      logic [7:0] rot;
      rot = {sum[0], sum[7:1]};
      return rot + b;
   endfunction

endpackage

`default_nettype wire

FILE: design/spd_csr.sv
// ---------------------------------------------------------------------------
// Deframer register block
// Holds the head and tail byte values behind a simple APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module spd_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [spd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready,
   output spd_pkg::spd_cfg_type             cfg
);
   import spd_pkg::*;

   logic [7:0] head_ff, head_in;
   logic [7:0] tail_ff, tail_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // Decode writes
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_HEAD: head_in = pwdata[7:0];
            REG_TAIL: tail_in = pwdata[7:0];
            default:  head_in = head_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         tail_ff <= TAIL_RESET;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         REG_HEAD: prdata = {24'd0, head_ff};
         REG_TAIL: prdata = {24'd0, tail_ff};
         default:  prdata = 32'd0;
      endcase
   end

   assign cfg.head_byte = head_ff;
   assign cfg.tail_byte = tail_ff;

endmodule

`default_nettype wire

FILE: design/spd_parser.sv
// ---------------------------------------------------------------------------
// Deframer frame parser
// Frame state and the per-byte next-state and result logic.
// ---------------------------------------------------------------------------
`default_nettype none

module spd_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             rx_byte,
   input  wire spd_pkg::spd_cfg_type   cfg,
   output spd_pkg::spd_result_type     result
);
   import spd_pkg::*;

   spd_phase_type phase_ff, phase_in;
   logic [7:0]    exp_len_ff, exp_len_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    msg_id_ff, msg_id_in;
   logic [7:0]    count_inc;
   spd_err_type   fail;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      msg_id_in  = msg_id_ff;
      fail       = ERR_NONE;
      result     = '{payload_byte: BYTE_ZERO, payload_valid: 1'b0, first_of_frame: 1'b0,
                     frame_done: 1'b0, frame_good: 1'b0, error_code: ERR_NONE,
                     frame_id: BYTE_ZERO, frame_length: BYTE_ZERO};

      case (phase_ff)
         PH_LEN: begin
            if ((rx_byte == BYTE_ZERO) || (rx_byte > MAX_PAYLOAD)) begin
               result.frame_done   = 1'b1;
               result.error_code   = ERR_LENGTH;
               result.frame_length = rx_byte;
               phase_in   = PH_IDLE;
               exp_len_in = BYTE_ZERO;
               count_in   = BYTE_ZERO;
               sum_in     = BYTE_ZERO;
               msg_id_in  = BYTE_ZERO;
            end else begin
               exp_len_in = rx_byte;
               count_in   = BYTE_ZERO;
               sum_in     = BYTE_ZERO;
               phase_in   = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            result.payload_byte  = rx_byte;
            result.payload_valid = 1'b1;
            if (count_ff == BYTE_ZERO) begin
               result.first_of_frame = 1'b1;
               msg_id_in             = rx_byte;
            end
            count_in = count_inc;
            sum_in   = bsd_add(sum_ff, rx_byte);
            if (count_inc >= exp_len_ff) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            if (rx_byte == cfg.tail_byte) phase_in = PH_CHECKSUM;
            else fail = ERR_TAIL;
         end
         PH_CHECKSUM: begin
            if (rx_byte == sum_ff) phase_in = PH_CR;
            else fail = ERR_CHECKSUM;
         end
         PH_CR: begin
            if (rx_byte == BYTE_CR) phase_in = PH_LF;
            else fail = ERR_CR;
         end
         PH_LF: begin
            result.frame_done   = 1'b1;
            result.frame_id     = msg_id_ff;
            result.frame_length = exp_len_ff;
            if (rx_byte == BYTE_LF) result.frame_good = 1'b1;
            else result.error_code = ERR_LF;
            phase_in   = PH_IDLE;
            exp_len_in = BYTE_ZERO;
            count_in   = BYTE_ZERO;
            sum_in     = BYTE_ZERO;
            msg_id_in  = BYTE_ZERO;
         end
         default: begin
            // Idle, or a phase code that means nothing: hunt for the head byte
            phase_in   = (rx_byte == cfg.head_byte) ? PH_LEN : PH_IDLE;
            exp_len_in = BYTE_ZERO;
            count_in   = BYTE_ZERO;
            sum_in     = BYTE_ZERO;
            msg_id_in  = BYTE_ZERO;
            if (rx_byte != cfg.head_byte) result.error_code = ERR_STRAY;
         end
      endcase

      // End the frame on a failed check and drop its state
      if (fail != ERR_NONE) begin
         result.frame_done   = 1'b1;
         result.error_code   = fail;
         result.frame_id     = msg_id_ff;
         result.frame_length = exp_len_ff;
         phase_in   = PH_IDLE;
         exp_len_in = BYTE_ZERO;
         count_in   = BYTE_ZERO;
         sum_in     = BYTE_ZERO;
         msg_id_in  = BYTE_ZERO;
      end
   end

   // Advance frame state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_len_ff <= BYTE_ZERO;
         count_ff   <= BYTE_ZERO;
         sum_ff     <= BYTE_ZERO;
         msg_id_ff  <= BYTE_ZERO;
      end else if (step) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         msg_id_ff  <= msg_id_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/serial_packet_deframer.sv
// ---------------------------------------------------------------------------
// Serial packet deframer
// Parses received bytes into framed packets with a BSD checksum.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per item; rsp_* returns exactly one
//   result item per byte, in order. Frame layout: head byte, length, payload
//   (first byte is the message id), tail byte, BSD checksum, CR, LF.
//   Payload bytes are echoed as they arrive; the last byte of a frame, or
//   the byte that breaks it, carries frame_done with frame_good and an
//   error code. Head and tail byte values sit in two registers behind the
//   APB-style port (head at 0x0, tail at 0x4); write them only while idle.
//   A byte accepted on req_* passes the input register, then the result
//   register, before it shows on rsp_*. Throughput: one byte per cycle
//   while rsp_stall is low, the frame state updating once per byte
//   between the two. A stalled result holds; the input register still takes
//   one more byte, and req_stall rises only when both registers are full.
//   Reset (synchronous): both registers empty, parser idle and waiting for
//   the head byte, head and tail registers back to their reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_packet_deframer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Input channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_rx_byte,
   // Result channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [7:0]                  rsp_payload_byte,
   output logic                             rsp_payload_valid,
   output logic                             rsp_first_of_frame,
   output logic                             rsp_frame_done,
   output logic                             rsp_frame_good,
   output logic      [2:0]                  rsp_error_code,
   output logic      [7:0]                  rsp_frame_id,
   output logic      [7:0]                  rsp_frame_length,
   // Configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [spd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);
   import spd_pkg::*;

   spd_cfg_type    cfg;
   spd_result_type step_result;
   spd_result_type out_ff;
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff, out_valid_in;
   logic           advance;
   logic           req_fire;
   logic           rsp_fire;

   spd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   spd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // Handshake and pipeline advance
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_fire ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture input byte and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_payload_valid  = out_ff.payload_valid;
   assign rsp_first_of_frame = out_ff.first_of_frame;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_good     = out_ff.frame_good;
   assign rsp_error_code     = out_ff.error_code;
   assign rsp_frame_id       = out_ff.frame_id;
   assign rsp_frame_length   = out_ff.frame_length;

endmodule

`default_nettype wire

FILE: design/spd_checker.sv
// ---------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports and flags inconsistent result items.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_packet_deframer_assert.svh"

module spd_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_payload_byte,
   input  wire logic       rsp_payload_valid,
   input  wire logic       rsp_first_of_frame,
   input  wire logic       rsp_frame_done,
   input  wire logic       rsp_frame_good,
   input  wire logic [2:0] rsp_error_code
);
   import spd_pkg::*;

   // Hold a stalled result item
   `SPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_frame_done)
      && $stable(rsp_error_code))

   // No result item right after reset
   `SPD_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // A good frame ends cleanly with no error code
   `SPD_ASSERT_NOW(a_good_clean, clock, reset, rsp_valid && rsp_frame_good,
      rsp_frame_done && (rsp_error_code == ERR_NONE) && !rsp_payload_valid)

   // The message id is a payload byte and never ends a frame
   `SPD_ASSERT_NOW(a_first_payload, clock, reset, rsp_valid && rsp_first_of_frame,
      rsp_payload_valid && !rsp_frame_done && (rsp_error_code == ERR_NONE))

endmodule

bind serial_packet_deframer spd_checker u_spd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_valid  (rsp_payload_valid),
   .rsp_first_of_frame (rsp_first_of_frame),
   .rsp_frame_done     (rsp_frame_done),
   .rsp_frame_good     (rsp_frame_good),
   .rsp_error_code     (rsp_error_code)
);

`default_nettype wire

FILE: test/tb_serial_packet_deframer.sv
// ---------------------------------------------------------------------------
// Serial packet deframer testbench
// Feeds byte streams of good, broken and truncated frames plus line noise
// into the deframer under several head/tail register settings, predicts the
// result of every byte and checks each result field by field, in order.
// ---------------------------------------------------------------------------

module tb_serial_packet_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import spd_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 40;
   localparam logic [ADDR_W-1:0] ADDR_HEAD = {REG_HEAD, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_TAIL = {REG_TAIL, 2'b00};

   // Ways a generated frame can be broken
   typedef enum int {
      FLT_NONE,
      FLT_TAIL,
      FLT_SUM,
      FLT_CR,
      FLT_LF,
      FLT_LEN,
      FLT_CUT
   } frame_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_first_of_frame;
   logic        rsp_frame_done;
   logic        rsp_frame_good;
   logic [2:0]  rsp_error_code;
   logic [7:0]  rsp_frame_id;
   logic [7:0]  rsp_frame_length;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Byte stream waiting to be sent, and results predicted for sent bytes
   logic [7:0]     rx_stream[$];
   spd_result_type pending_results[$];
   spd_result_type want;

   // Predictor copy of the registers and the frame state
   logic [7:0]    cfg_head = HEAD_RESET;
   logic [7:0]    cfg_tail = TAIL_RESET;
   spd_phase_type fr_phase = PH_IDLE;
   logic [7:0]    fr_len = '0;
   logic [7:0]    fr_count = '0;
   logic [7:0]    fr_sum = '0;
   logic [7:0]    fr_id = '0;

   // Register values the stimulus builds frames for
   logic [7:0] gen_head = HEAD_RESET;
   logic [7:0] gen_tail = TAIL_RESET;

   // Handshake bookkeeping
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   int   req_wait = 0;
   int   rsp_wait = 0;
   int   req_gap_max = 0;
   int   rsp_gap_max = 0;
   logic hold_request = 1'b0;
   int   hold_left = 0;
   int   stuck_cycles = 0;

   // Run statistics
   int mismatches = 0;
   int bytes_queued = 0;
   int results_checked = 0;
   int frames_good = 0;
   int frames_broken = 0;
   int stray_bytes = 0;
   int settings_used = 1;

   serial_packet_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_good     (rsp_frame_good),
      .rsp_error_code     (rsp_error_code),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_frame_length   (rsp_frame_length),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #6 clock = ~clock;

   // Rotate the running sum right by one, then add the byte
   function automatic logic [7:0] checksum_step(input logic [7:0] sum, input logic [7:0] b);
      return {sum[0], sum[7:1]} + b;
   endfunction

   // Drop the open frame and return to hunting for a head byte
   function automatic void drop_frame();
      fr_phase = PH_IDLE;
      fr_len   = '0;
      fr_count = '0;
      fr_sum   = '0;
      fr_id    = '0;
   endfunction

   // Advance the frame parser by one byte and return the result it gives
   function automatic spd_result_type deframe_byte(input logic [7:0] b);
      spd_result_type r;
      spd_err_type    fail;
      r    = '0;
      fail = ERR_NONE;
      case (fr_phase)
         PH_LEN: begin
            if (b == BYTE_ZERO || b > MAX_PAYLOAD) begin
               r.frame_done   = 1'b1;
               r.error_code   = ERR_LENGTH;
               r.frame_length = b;
               drop_frame();
            end else begin
               fr_len   = b;
               fr_count = '0;
               fr_sum   = '0;
               fr_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            if (fr_count == 8'd0) begin
               r.first_of_frame = 1'b1;
               fr_id = b;
            end
            fr_count = fr_count + 8'd1;
            fr_sum   = checksum_step(fr_sum, b);
            if (fr_count >= fr_len) fr_phase = PH_TAIL;
         end
         PH_TAIL: begin
            if (b == cfg_tail) fr_phase = PH_CHECKSUM;
            else fail = ERR_TAIL;
         end
         PH_CHECKSUM: begin
            if (b == fr_sum) fr_phase = PH_CR;
            else fail = ERR_CHECKSUM;
         end
         PH_CR: begin
            if (b == BYTE_CR) fr_phase = PH_LF;
            else fail = ERR_CR;
         end
         PH_LF: begin
            r.frame_done   = 1'b1;
            r.frame_id     = fr_id;
            r.frame_length = fr_len;
            if (b == BYTE_LF) r.frame_good = 1'b1;
            else r.error_code = ERR_LF;
            drop_frame();
         end
         default: begin
            drop_frame();
            if (b == cfg_head) fr_phase = PH_LEN;
            else r.error_code = ERR_STRAY;
         end
      endcase
      // A failed check closes the frame with its id and length
      if (fail != ERR_NONE) begin
         r.frame_done   = 1'b1;
         r.error_code   = fail;
         r.frame_id     = fr_id;
         r.frame_length = fr_len;
         drop_frame();
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      end
   endfunction

   // Predict accepted bytes, check results, mirror register traffic
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
         rsp_fired = 1'b0;
         cfg_head  = HEAD_RESET;
         cfg_tail  = TAIL_RESET;
         drop_frame();
      end else begin
         req_fired = req_valid && !req_stall;
         rsp_fired = rsp_valid && !rsp_stall;
         if (req_fired) begin
            want = deframe_byte(req_rx_byte);
            if (want.frame_done && want.frame_good) frames_good++;
            else if (want.frame_done) frames_broken++;
            else if (want.error_code == ERR_STRAY) stray_bytes++;
            pending_results.push_back(want);
         end
         if (rsp_fired) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result item with nothing expected, expected none, got %0h",
                           $time, rsp_payload_byte);
            end else begin
               want = pending_results.pop_front();
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               check_field("payload_valid", 32'(want.payload_valid), 32'(rsp_payload_valid));
               check_field("first_of_frame", 32'(want.first_of_frame),
                           32'(rsp_first_of_frame));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
               check_field("frame_good", 32'(want.frame_good), 32'(rsp_frame_good));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("frame_id", 32'(want.frame_id), 32'(rsp_frame_id));
               check_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
            end
         end
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ADDR_HEAD) cfg_head = pwdata[7:0];
               else if (paddr == ADDR_TAIL) cfg_tail = pwdata[7:0];
            end else if (paddr == ADDR_HEAD) begin
               check_field("head_byte read", {24'h0, cfg_head}, prdata);
            end else if (paddr == ADDR_TAIL) begin
               check_field("tail_byte read", {24'h0, cfg_tail}, prdata);
            end
         end
      end
   end

   // Offer the next byte once the current one is taken and its gap is over
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (rx_stream.size() > 0) begin
            req_rx_byte <= rx_stream.pop_front();
            req_valid   <= 1'b1;
            req_wait    = $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel: a random wait per item, or one long hold-off
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (rsp_fired) rsp_wait = $urandom_range(0, rsp_gap_max);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
         $display("serial_packet_deframer: mismatch");
         $finish;
      end
   end

   function automatic void push_byte(input logic [7:0] b);
      rx_stream.push_back(b);
      bytes_queued++;
   endfunction

   // Pick a wrong byte: sometimes the head value, else a flipped good value
   function automatic logic [7:0] spoil(input logic [7:0] good_v);
      if ($urandom_range(0, 3) == 0 && gen_head != good_v) return gen_head;
      return good_v ^ 8'($urandom_range(1, 255));
   endfunction

   // Mostly short payloads, now and then a long one up to the maximum
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 40);
      if (r < 99) return $urandom_range(100, 127);
      return MAX_PAYLOAD;
   endfunction

   // Queue one frame, broken at the given point; fill < 0 means random payload
   task automatic queue_frame(input int len, input frame_fault_type fault, input int fill);
      logic [7:0] sum;
      logic [7:0] pb;
      int         n;
      sum = '0;
      push_byte(gen_head);
      if (fault == FLT_LEN) begin
         push_byte(($urandom_range(0, 1) == 0) ? BYTE_ZERO : 8'($urandom_range(129, 255)));
         return;
      end
      push_byte(8'(len));
      n = (fault == FLT_CUT) ? $urandom_range(0, len - 1) : len;
      for (int i = 0; i < n; i++) begin
         pb  = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         sum = checksum_step(sum, pb);
         push_byte(pb);
      end
      if (fault == FLT_CUT) return;
      push_byte((fault == FLT_TAIL) ? spoil(gen_tail) : gen_tail);
      if (fault == FLT_TAIL) return;
      push_byte((fault == FLT_SUM) ? spoil(sum) : sum);
      if (fault == FLT_SUM) return;
      push_byte((fault == FLT_CR) ? spoil(BYTE_CR) : BYTE_CR);
      if (fault == FLT_CR) return;
      push_byte((fault == FLT_LF) ? spoil(BYTE_LF) : BYTE_LF);
   endtask

   // Queue about n bytes: mostly good frames, some broken ones, some noise
   task automatic run_random(input int n);
      int start;
      int pick;
      start = bytes_queued;
      while (bytes_queued - start < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            queue_frame(pick_len(), FLT_NONE, -1);
         else if (pick < 90)
            queue_frame(pick_len(), frame_fault_type'($urandom_range(FLT_TAIL, FLT_CUT)), -1);
         else
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // One register access: setup phase, then access phase
   task automatic bus_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [7:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= {24'($urandom_range(0, 32'h00FF_FFFF)), val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait until every queued byte has produced its checked result
   task automatic wait_drained();
      while (results_checked < bytes_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   logic [7:0] head_plan [6] = '{8'h00, 8'hFF, 8'h0D, 8'h5A, 8'h00, 8'h00};
   logic [7:0] tail_plan [6] = '{8'hFF, 8'h00, 8'h0A, 8'h5A, 8'h00, 8'h00};
   int         req_plan  [6] = '{0, 8, 0, 8, 3, 8};
   int         rsp_plan  [6] = '{8, 0, 0, 8, 5, 8};

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset values of both registers
      bus_access(1'b0, ADDR_HEAD, 8'h00);
      bus_access(1'b0, ADDR_TAIL, 8'h00);

      // Directed: stray bytes, bad lengths at both ends, short frames
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(gen_head);
      push_byte(BYTE_ZERO);
      push_byte(gen_head);
      push_byte(8'hFF);
      push_byte(gen_head);
      push_byte(MAX_PAYLOAD + 8'd1);
      queue_frame(1, FLT_NONE, 255);
      queue_frame(1, FLT_TAIL, 0);
      queue_frame(1, FLT_SUM, -1);
      wait_drained();

      req_gap_max = 8;
      rsp_gap_max = 8;
      run_random(250);
      wait_drained();

      head_plan[4] = 8'($urandom_range(0, 255));
      tail_plan[4] = 8'($urandom_range(0, 255));
      head_plan[5] = 8'($urandom_range(0, 255));
      tail_plan[5] = 8'($urandom_range(0, 255));

      for (int k = 0; k < 6; k++) begin
         // Reprogram only while no byte is in flight, then read back
         bus_access(1'b1, ADDR_HEAD, head_plan[k]);
         bus_access(1'b1, ADDR_TAIL, tail_plan[k]);
         bus_access(1'b0, ADDR_HEAD, 8'h00);
         bus_access(1'b0, ADDR_TAIL, 8'h00);
         gen_head    = head_plan[k];
         gen_tail    = tail_plan[k];
         settings_used++;
         req_gap_max = req_plan[k];
         rsp_gap_max = rsp_plan[k];
         run_random(270);
         // Hold off the receiver while the sender keeps offering bytes
         if (k == 0) begin
            while (results_checked < bytes_queued - 180) @(negedge clock);
            hold_request = 1'b1;
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (pending_results.size() != 0) begin
         mismatches++;
         $display("%0t: results left over, expected 0, got %0d",
                  $time, pending_results.size());
      end
      $display("Sent %0d bytes and checked %0d results under %0d head/tail settings.",
               bytes_queued, results_checked, settings_used);
      $display("Frames closed: %0d good, %0d broken; %0d stray bytes outside frames.",
               frames_good, frames_broken, stray_bytes);
      if (mismatches == 0)
         $display("serial_packet_deframer: match");
      else
         $display("serial_packet_deframer: mismatch");
      $finish;
   end

endmodule
